FILE: hw/rtl/rcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB 3x3 convolution package
// Shared constants, register indexes and payload types of the filter block.
// ----------------------------------------------------------------------------
package rcc_pkg;

  localparam int DefMaxWidth    = 1024;
  localparam int DefMaxHeight   = 4096;

  // Register reset values and raw field widths.
  localparam int RegWidthReset  = 1024;
  localparam int RegHeightReset = 1;
  localparam int GeomWidthBits  = 11;
  localparam int GeomHeightBits = 13;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Accumulator width: nine products of 8u x 8s fit in 20 signed bits.
  localparam int SumW   = 20;
  localparam int PixMax = 255;

  localparam logic CmdPixel = 1'b0;
  localparam logic CmdFlush = 1'b1;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCenterCoef  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegEdgeCoefs   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCornerCoefs = 3'd4;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Window indexed [row][col]; row 0 is the upper row, col 2 the newest column.
  typedef rgb_t [2:0][2:0] window_t;

  // One line buffer entry: the pixel two rows back and the pixel one row back.
  typedef struct packed {
    rgb_t upper;
    rgb_t lower;
  } line_pair_t;

  typedef struct packed {
    logic [31:0] corners;
    logic [31:0] edges;
    logic [7:0]  center;
  } coef_set_t;

  // Per-item control that travels with a window shift.
  typedef struct packed {
    logic emit;
    logic frame_end;
    logic top;
    logic bottom;
    logic left;
    logic right;
  } tap_ctrl_t;

endpackage

FILE: hw/rtl/rcc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB 3x3 convolution channel interfaces
// Pixel input stream, filtered pixel output stream and register write channel.
// ----------------------------------------------------------------------------
interface rcc_pix_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, cmd, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, cmd, red_in, green_in, blue_in, output ready);
endinterface

interface rcc_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

interface rcc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rcc_pkg::CfgIdxW-1:0]  index;
  logic [rcc_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/rcc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, read-first output.
// ----------------------------------------------------------------------------
module rcc_ram #(
  parameter int  WIDTH = $bits(rcc_pkg::line_pair_t),
  parameter int  DEPTH = rcc_pkg::DefMaxWidth,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/rcc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB 3x3 convolution register file
// Holds the frame geometry, clamped to the supported range, and the weights.
// ----------------------------------------------------------------------------
module rcc_regs #(
  parameter int  MAX_WIDTH  = rcc_pkg::DefMaxWidth,
  parameter int  MAX_HEIGHT = rcc_pkg::DefMaxHeight,
  localparam int WW         = $clog2(MAX_WIDTH + 1),
  localparam int HW         = $clog2(MAX_HEIGHT + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rcc_cfg_if.sink            cfg,
  output logic [WW-1:0]      width_o,
  output logic [HW-1:0]      height_o,
  output rcc_pkg::coef_set_t coefs_o,
  output logic               restart_o
);

  localparam logic [WW-1:0] WidthRst = WW'((rcc_pkg::RegWidthReset > MAX_WIDTH) ?
                                           MAX_WIDTH : rcc_pkg::RegWidthReset);
  localparam logic [HW-1:0] HeightRst = HW'(rcc_pkg::RegHeightReset);

  logic [WW-1:0]      width_q, width_d;
  logic [HW-1:0]      height_q, height_d;
  rcc_pkg::coef_set_t coefs_q, coefs_d;
  logic               wr;
  logic [rcc_pkg::GeomWidthBits-1:0]  w_raw;
  logic [rcc_pkg::GeomHeightBits-1:0] h_raw;
  logic [WW-1:0]      w_eff;
  logic [HW-1:0]      h_eff;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;
  assign w_raw     = cfg.data[rcc_pkg::GeomWidthBits-1:0];
  assign h_raw     = cfg.data[rcc_pkg::GeomHeightBits-1:0];

  // A zero size acts as one, anything beyond the maximum as the maximum.
  always_comb begin
    if (w_raw == '0) begin
      w_eff = WW'(1);
    end else if (32'(w_raw) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w_raw);
    end
    if (h_raw == '0) begin
      h_eff = HW'(1);
    end else if (32'(h_raw) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(h_raw);
    end
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    coefs_d  = coefs_q;
    if (wr) begin
      unique case (cfg.index)
        rcc_pkg::RegImageWidth:  width_d         = w_eff;
        rcc_pkg::RegImageHeight: height_d        = h_eff;
        rcc_pkg::RegCenterCoef:  coefs_d.center  = cfg.data[7:0];
        rcc_pkg::RegEdgeCoefs:   coefs_d.edges   = cfg.data;
        rcc_pkg::RegCornerCoefs: coefs_d.corners = cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      coefs_q  <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      coefs_q  <= coefs_d;
    end
  end

  assign restart_o = wr && (cfg.index == rcc_pkg::RegImageWidth ||
                            cfg.index == rcc_pkg::RegImageHeight);
  assign width_o   = width_q;
  assign height_o  = height_q;
  assign coefs_o   = coefs_q;

endmodule

FILE: hw/rtl/rcc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB 3x3 convolution frame control
// Tracks input and output positions, decides per item whether the window
// advances and emits, and holds the first pipeline stage.
// ----------------------------------------------------------------------------
module rcc_ctrl #(
  parameter int  MAX_WIDTH  = rcc_pkg::DefMaxWidth,
  parameter int  MAX_HEIGHT = rcc_pkg::DefMaxHeight,
  localparam int WW         = $clog2(MAX_WIDTH + 1),
  localparam int HW         = $clog2(MAX_HEIGHT + 1),
  localparam int AW         = $clog2(MAX_WIDTH),
  localparam int RW         = $clog2(MAX_HEIGHT),
  localparam int LW         = $clog2(MAX_WIDTH + 2)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rcc_pix_in_if.sink         pix_in,
  input  logic [WW-1:0]      width_i,
  input  logic [HW-1:0]      height_i,
  input  logic               restart_i,
  input  logic               s1_go_i,
  output logic               s1_valid_o,
  output rcc_pkg::rgb_t      s1_pix_o,
  output logic [AW-1:0]      s1_ptr_o,
  output rcc_pkg::tap_ctrl_t s1_tap_o,
  output logic               rd_en_o,
  output logic [AW-1:0]      rd_addr_o
);

  logic [AW-1:0] in_col_q, in_col_d;
  logic [HW-1:0] in_row_q, in_row_d;
  logic [LW-1:0] lead_q, lead_d;
  logic [AW-1:0] ocol_q, ocol_d;
  logic [RW-1:0] orow_q, orow_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          s1_v_q, s1_v_d;
  rcc_pkg::rgb_t      s1_pix_q;
  logic [AW-1:0]      s1_ptr_q;
  rcc_pkg::tap_ctrl_t s1_tap_q, tap;

  logic accept, pix_done, adv, is_pix, emit;
  logic in_last_col, o_last_col, o_last_row, ptr_last;

  assign pix_in.ready = !s1_v_q || s1_go_i;
  assign accept       = pix_in.valid && pix_in.ready;

  // Once every pixel of the frame is in, each item only pushes the window on.
  assign pix_done = (in_row_q == height_i);
  assign is_pix   = (pix_in.cmd == rcc_pkg::CmdPixel) && !pix_done;
  assign adv      = accept && ((pix_in.cmd == rcc_pkg::CmdPixel) || pix_done);

  assign in_last_col = (WW'(in_col_q) == width_i - WW'(1));
  assign o_last_col  = (WW'(ocol_q) == width_i - WW'(1));
  assign o_last_row  = (HW'(orow_q) == height_i - HW'(1));
  assign ptr_last    = (WW'(ptr_q) == width_i - WW'(1));
  assign emit        = (lead_q == LW'(width_i) + LW'(1));

  always_comb begin
    tap.emit      = emit;
    tap.frame_end = emit && o_last_col && o_last_row;
    tap.top       = (orow_q == '0);
    tap.bottom    = o_last_row;
    tap.left      = (ocol_q == '0);
    tap.right     = o_last_col;
  end

  always_comb begin
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    lead_d   = lead_q;
    ocol_d   = ocol_q;
    orow_d   = orow_q;
    ptr_d    = ptr_q;
    if (restart_i || (adv && tap.frame_end)) begin
      in_col_d = '0;
      in_row_d = '0;
      lead_d   = '0;
      ocol_d   = '0;
      orow_d   = '0;
      ptr_d    = '0;
    end else if (adv) begin
      ptr_d = ptr_last ? '0 : ptr_q + AW'(1);
      if (is_pix) begin
        if (in_last_col) begin
          in_col_d = '0;
          in_row_d = in_row_q + HW'(1);
        end else begin
          in_col_d = in_col_q + AW'(1);
        end
      end
      if (emit) begin
        if (o_last_col) begin
          ocol_d = '0;
          orow_d = orow_q + RW'(1);
        end else begin
          ocol_d = ocol_q + AW'(1);
        end
      end else begin
        lead_d = lead_q + LW'(1);
      end
    end
  end

  always_comb begin
    priority if (adv) begin
      s1_v_d = 1'b1;
    end else if (s1_go_i) begin
      s1_v_d = 1'b0;
    end else begin
      s1_v_d = s1_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      lead_q   <= '0;
      ocol_q   <= '0;
      orow_q   <= '0;
      ptr_q    <= '0;
      s1_v_q   <= 1'b0;
    end else begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      lead_q   <= lead_d;
      ocol_q   <= ocol_d;
      orow_q   <= orow_d;
      ptr_q    <= ptr_d;
      s1_v_q   <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pix_q.red   <= pix_in.red_in;
      s1_pix_q.green <= pix_in.green_in;
      s1_pix_q.blue  <= pix_in.blue_in;
      s1_ptr_q       <= ptr_q;
      s1_tap_q       <= tap;
    end
  end

  assign rd_en_o    = adv;
  assign rd_addr_o  = ptr_q;
  assign s1_valid_o = s1_v_q;
  assign s1_pix_o   = s1_pix_q;
  assign s1_ptr_o   = s1_ptr_q;
  assign s1_tap_o   = s1_tap_q;

endmodule

FILE: hw/rtl/rcc_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB 3x3 convolution line buffer and window
// A one-row-deep RAM holds pairs of pixels one and two rows back; the 3x3
// window shifts left by one column for every advancing item.
// ----------------------------------------------------------------------------
module rcc_window #(
  parameter int  MAX_WIDTH = rcc_pkg::DefMaxWidth,
  localparam int AW        = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic             s1_go_i,
  input  rcc_pkg::rgb_t    s1_pix_i,
  input  logic [AW-1:0]    s1_ptr_i,
  output rcc_pkg::window_t window_o
);

  rcc_pkg::line_pair_t ram_pair, rd_pair, wr_pair, byp_pair_q;
  logic                byp_q;
  rcc_pkg::window_t    win_q, win_d;

  rcc_ram #(
    .WIDTH ($bits(rcc_pkg::line_pair_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_go_i),
    .waddr_i (s1_ptr_i),
    .wdata_i (wr_pair),
    .re_i    (rd_en_i),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_pair)
  );

  // An item's write lands as it leaves the control stage, after its read; with
  // a one-pixel row the next read hits the entry being written; it is forwarded.
  assign rd_pair       = byp_q ? byp_pair_q : ram_pair;
  assign wr_pair.upper = rd_pair.lower;
  assign wr_pair.lower = s1_pix_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= s1_go_i && (s1_ptr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      byp_pair_q <= wr_pair;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = rd_pair.upper;
    win_d[1][2] = rd_pair.lower;
    win_d[2][2] = s1_pix_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_go_i) begin
      win_q <= win_d;
    end
  end

  assign window_o = win_q;

endmodule

FILE: hw/rtl/rcc_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB 3x3 convolution arithmetic
// Masks taps outside the image, applies the nine signed weights per channel
// and clamps each sum to the pixel range.
// ----------------------------------------------------------------------------
module rcc_filter (
  input  rcc_pkg::window_t   window_i,
  input  rcc_pkg::tap_ctrl_t tap_i,
  input  rcc_pkg::coef_set_t coefs_i,
  output rcc_pkg::rgb_t      result_o
);

  logic [2:0][2:0][7:0] k;
  logic [8:0][7:0]      kf, red_px, green_px, blue_px;
  logic                 keep;

  function automatic logic [7:0] mac_clamp(input logic [8:0][7:0] px,
                                           input logic [8:0][7:0] w);
    logic signed [rcc_pkg::SumW-1:0] acc;
    logic signed [8:0]               a;
    logic signed [7:0]               b;
    logic signed [16:0]              p;
    acc = '0;
    for (int i = 0; i < 9; i++) begin
      a   = {1'b0, px[i]};
      b   = w[i];
      p   = a * b;
      acc = acc + rcc_pkg::SumW'(p);
    end
    if (acc[rcc_pkg::SumW-1]) begin
      mac_clamp = '0;
    end else if (acc > rcc_pkg::SumW'(rcc_pkg::PixMax)) begin
      mac_clamp = 8'(rcc_pkg::PixMax);
    end else begin
      mac_clamp = acc[7:0];
    end
  endfunction

  always_comb begin
    k[0][0] = coefs_i.corners[7:0];
    k[0][1] = coefs_i.edges[7:0];
    k[0][2] = coefs_i.corners[15:8];
    k[1][0] = coefs_i.edges[23:16];
    k[1][1] = coefs_i.center;
    k[1][2] = coefs_i.edges[31:24];
    k[2][0] = coefs_i.corners[23:16];
    k[2][1] = coefs_i.edges[15:8];
    k[2][2] = coefs_i.corners[31:24];
  end

  // Taps that fall outside the frame read as black.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        keep = !((r == 0) && tap_i.top) && !((r == 2) && tap_i.bottom) &&
               !((c == 0) && tap_i.left) && !((c == 2) && tap_i.right);
        kf[r*3+c]       = k[r][c];
        red_px[r*3+c]   = keep ? window_i[r][c].red   : 8'h00;
        green_px[r*3+c] = keep ? window_i[r][c].green : 8'h00;
        blue_px[r*3+c]  = keep ? window_i[r][c].blue  : 8'h00;
      end
    end
  end

  assign result_o.red   = mac_clamp(red_px, kf);
  assign result_o.green = mac_clamp(green_px, kf);
  assign result_o.blue  = mac_clamp(blue_px, kf);

endmodule

FILE: hw/rtl/rgb_conv3x3_clamp.sv
`timescale 1ns / 1ps
// Path: a result is loaded into the output register when the item completing
// its window leaves the second stage, W+1 items after its pixel.
// Throughput: one item per cycle, flush ticks included, unless output stalls.
// Reset: counters, pipeline valids, window and registers return to defaults;
// the line RAM is not cleared, and no clearing pass runs after reset.
// ----------------------------------------------------------------------------
// RGB 3x3 convolution with clamping
// Streams RGB pixels in raster order through two rows of line storage and a
// 3x3 window, and emits per-channel weighted sums clamped to 0..255.
// ----------------------------------------------------------------------------
module rgb_conv3x3_clamp #(
  parameter int MAX_WIDTH  = rcc_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = rcc_pkg::DefMaxHeight
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rcc_pix_in_if.sink  pix_in,
  rcc_pix_out_if.source pix_out,
  rcc_cfg_if.sink     cfg
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(MAX_WIDTH);

  // Pipeline: the control stage registers each advancing item and issues the
  // line RAM read; the next stage shifts the window; the filter then feeds
  // the output register. Each stage may load whenever it is empty or its
  // content moves on, so bubbles collapse and a waiting result does not stop
  // input while an earlier stage has room.

  logic [WW-1:0]      width;
  logic [HW-1:0]      height;
  rcc_pkg::coef_set_t coefs;
  logic               restart;

  logic               s1_valid, s1_go;
  rcc_pkg::rgb_t      s1_pix;
  logic [AW-1:0]      s1_ptr;
  rcc_pkg::tap_ctrl_t s1_tap;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;

  rcc_pkg::window_t   window;
  rcc_pkg::rgb_t      result;

  logic               s2_v_q, s2_v_d, s2_go, s2_free;
  rcc_pkg::tap_ctrl_t s2_tap_q;
  logic               out_v_q, out_v_d, out_free, out_load;
  rcc_pkg::rgb_t      out_rgb_q;
  logic               out_fe_q;

  rcc_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg       (cfg),
    .width_o   (width),
    .height_o  (height),
    .coefs_o   (coefs),
    .restart_o (restart)
  );

  rcc_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_in     (pix_in),
    .width_i    (width),
    .height_i   (height),
    .restart_i  (restart),
    .s1_go_i    (s1_go),
    .s1_valid_o (s1_valid),
    .s1_pix_o   (s1_pix),
    .s1_ptr_o   (s1_ptr),
    .s1_tap_o   (s1_tap),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr)
  );

  // The window shifts exactly when the control stage hands its item on, so
  // the window contents always belong to the item held in the second stage.
  rcc_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .s1_go_i   (s1_go),
    .s1_pix_i  (s1_pix),
    .s1_ptr_i  (s1_ptr),
    .window_o  (window)
  );

  rcc_filter u_filter (
    .window_i (window),
    .tap_i    (s2_tap_q),
    .coefs_i  (coefs),
    .result_o (result)
  );

  // Items that only fill the window leave the second stage without a result.
  assign out_free = !out_v_q || pix_out.ready;
  assign s2_go    = s2_v_q && (!s2_tap_q.emit || out_free);
  assign s2_free  = !s2_v_q || s2_go;
  assign s1_go    = s1_valid && s2_free;
  assign out_load = s2_go && s2_tap_q.emit;

  always_comb begin
    priority if (s1_go) begin
      s2_v_d = 1'b1;
    end else if (s2_go) begin
      s2_v_d = 1'b0;
    end else begin
      s2_v_d = s2_v_q;
    end
    priority if (out_load) begin
      out_v_d = 1'b1;
    end else if (pix_out.ready) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s2_v_q  <= s2_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_tap_q <= s1_tap;
    end
    if (out_load) begin
      out_rgb_q <= result;
      out_fe_q  <= s2_tap_q.frame_end;
    end
  end

  assign pix_out.valid     = out_v_q;
  assign pix_out.red_out   = out_rgb_q.red;
  assign pix_out.green_out = out_rgb_q.green;
  assign pix_out.blue_out  = out_rgb_q.blue;
  assign pix_out.frame_end = out_fe_q;

  // A held second stage must keep its window, so nothing may shift into it.
  a_no_shift_on_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !s2_go) |-> !s1_go)
    else $error("window shifted while the second stage was held");

  // The frame's last result sits at the bottom-right corner of the image.
  a_frame_end_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && s1_tap.frame_end) |-> (s1_tap.emit && s1_tap.bottom && s1_tap.right))
    else $error("frame end flagged away from the last pixel position");

  // An emitting item leaving the second stage always lands in the output.
  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_v_q)
    else $error("emitted result was not captured in the output register");

endmodule
